>>> src/gne_pkg.sv
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types, codes and pipeline constants for the 2D gradient noise block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gne_pkg;

  // Pipeline depth and the stage whose registers hold the table read data
  localparam int NSTAGE = 10;
  localparam int ST_RAM = 4;

  // Gradient table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int CODE_W      = 2;

  // Fixed-point constants (Q.16)
  localparam int FRAC_W   = 16;
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // Reciprocal shift for the grid-size wrap
  localparam int RECIP_SH = 24;

  // Signed widths of the blend path
  localparam int DOT_W  = 18;
  localparam int LERP_W = 20;

  // Request codes
  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Gradient direction codes
  localparam logic [CODE_W-1:0] DIR_POS_X = 2'd0;
  localparam logic [CODE_W-1:0] DIR_POS_Y = 2'd1;
  localparam logic [CODE_W-1:0] DIR_NEG_X = 2'd2;
  localparam logic [CODE_W-1:0] DIR_NEG_Y = 2'd3;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CODE_W-1:0]        code_t;
  typedef logic [FRAC_W-1:0]        frac_t;
  typedef logic [FRAC_W:0]          weight_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [LERP_W-1:0] lerp_t;

  // Per-stage load enables and valid flags of the pipeline
  typedef struct packed {
    logic [NSTAGE-1:0] ld;
    logic [NSTAGE-1:0] vld;
  } pipe_ctrl_t;

  // Dot product of a unit gradient with a corner offset
  function automatic dot_t grad_dot(code_t code, dot_t dx, dot_t dy);
    dot_t res;
    case (code)
      DIR_POS_X: res = dx;
      DIR_POS_Y: res = dy;
      DIR_NEG_X: res = -dx;
      DIR_NEG_Y: res = -dy;
      default:   res = dx;
    endcase
    return res;
  endfunction

endpackage

>>> src/gradient_noise_2d_eval.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_eval
// Accepts one word per clock and returns the noise value of each evaluation
// word in order; load words write the gradient table and return
// nothing. Throughput is one word per cycle, set by a ten-stage pipeline in
// which every stage holds one word and moves whenever the stage after it has
// room, so a stalled output only stops the words behind it once the stages
// fill. The gradient table is held twice, in two RAMs with two read ports
// each, so the four corner codes of one evaluation are read in a single
// cycle; table writes and reads happen in the same stage, in word order, so a
// load is seen by every evaluation accepted after it. Table contents are
// undefined after reset until loaded; only loaded entries should be read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_noise_2d_eval #(
  parameter int GRID_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               req_type,
  input  logic [31:0]        x_coord,
  input  logic [31:0]        y_coord,
  input  logic [11:0]        entry_index,
  input  logic [1:0]         entry_direction,
  output logic               noise_valid,
  input  logic               noise_ready,
  output logic signed [15:0] noise_value
);

  localparam int NS = gne_pkg::NSTAGE;

  gne_pkg::pipe_ctrl_t ctrl;
  logic [NS-1:0]       ld;
  logic [NS-1:0]       stage_valid, stage_valid_next;

  logic             req3;
  gne_pkg::addr_t   idx3, addr_tl, addr_tr, addr_bl, addr_br;
  gne_pkg::code_t   dir3, code_tl, code_tr, code_bl, code_br;
  gne_pkg::frac_t   fx0, fy0, fx3, fy3;
  gne_pkg::weight_t sx5, sy5;
  logic             tab_we, tab_re;

  // Stage load enables: a stage moves when empty or when the next one moves
  always_comb begin
    ld[NS-1] = !stage_valid[NS-1] || noise_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !stage_valid[k] || ld[k+1];
    end
  end

  // Advance valid flags; load words do not enter the table stage
  always_comb begin
    stage_valid_next = stage_valid;
    if (ld[0]) begin
      stage_valid_next[0] = item_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (ld[k]) begin
        stage_valid_next[k] = stage_valid[k-1];
      end
    end
    if (ld[gne_pkg::ST_RAM]) begin
      stage_valid_next[gne_pkg::ST_RAM] =
        stage_valid[gne_pkg::ST_RAM-1] && (req3 == gne_pkg::REQ_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign ctrl.ld     = ld;
  assign ctrl.vld    = stage_valid;
  assign item_ready  = ld[0];
  assign noise_valid = stage_valid[NS-1];

  // Table access: write a load word as it leaves stage three, read alongside
  assign tab_we = stage_valid[gne_pkg::ST_RAM-1] && (req3 == gne_pkg::REQ_LOAD)
               && ld[gne_pkg::ST_RAM];
  assign tab_re = ld[gne_pkg::ST_RAM];

  gne_addr #(
    .GRID_SIZE(GRID_SIZE)
  ) u_addr (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .req_type        (req_type),
    .x_coord         (x_coord),
    .y_coord         (y_coord),
    .entry_index     (entry_index),
    .entry_direction (entry_direction),
    .fx0             (fx0),
    .fy0             (fy0),
    .req3            (req3),
    .idx3            (idx3),
    .dir3            (dir3),
    .fx3             (fx3),
    .fy3             (fy3),
    .addr_tl         (addr_tl),
    .addr_tr         (addr_tr),
    .addr_bl         (addr_bl),
    .addr_br         (addr_br)
  );

  gne_ram #(
    .WIDTH(gne_pkg::CODE_W),
    .DEPTH(gne_pkg::TABLE_DEPTH)
  ) u_tab_top (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (idx3),
    .wdata   (dir3),
    .re      (tab_re),
    .raddr_a (addr_tl),
    .raddr_b (addr_tr),
    .rdata_a (code_tl),
    .rdata_b (code_tr)
  );

  gne_ram #(
    .WIDTH(gne_pkg::CODE_W),
    .DEPTH(gne_pkg::TABLE_DEPTH)
  ) u_tab_bot (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (idx3),
    .wdata   (dir3),
    .re      (tab_re),
    .raddr_a (addr_bl),
    .raddr_b (addr_br),
    .rdata_a (code_bl),
    .rdata_b (code_br)
  );

  gne_fade u_fade_x (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .t0   (fx0),
    .s5   (sx5)
  );

  gne_fade u_fade_y (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .t0   (fy0),
    .s5   (sy5)
  );

  gne_blend u_blend (
    .clk         (clk),
    .ctrl        (ctrl),
    .fx3         (fx3),
    .fy3         (fy3),
    .code_tl     (code_tl),
    .code_tr     (code_tr),
    .code_bl     (code_bl),
    .code_br     (code_br),
    .sx5         (sx5),
    .sy5         (sy5),
    .noise_value (noise_value)
  );

  // After a table write the table stage holds no valid word
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    tab_we |=> !stage_valid[gne_pkg::ST_RAM])
    else $error("load word reached the blend stages");

endmodule

>>> src/gne_ram.sv
// ----------------------------------------------------------------------------
// gne_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gne_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> src/gne_addr.sv
// ----------------------------------------------------------------------------
// gne_addr
// Input capture, grid wrap of the cell coordinates and corner address forming.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gne_addr #(
  parameter int GRID_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  gne_pkg::pipe_ctrl_t ctrl,
  input  logic                req_type,
  input  logic [31:0]         x_coord,
  input  logic [31:0]         y_coord,
  input  gne_pkg::addr_t      entry_index,
  input  gne_pkg::code_t      entry_direction,
  output gne_pkg::frac_t      fx0,
  output gne_pkg::frac_t      fy0,
  output logic                req3,
  output gne_pkg::addr_t      idx3,
  output gne_pkg::code_t      dir3,
  output gne_pkg::frac_t      fx3,
  output gne_pkg::frac_t      fy3,
  output gne_pkg::addr_t      addr_tl,
  output gne_pkg::addr_t      addr_tr,
  output gne_pkg::addr_t      addr_bl,
  output gne_pkg::addr_t      addr_br
);

  localparam int COL_W  = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int PROD_W = 16 + gne_pkg::RECIP_SH;
  localparam logic [gne_pkg::RECIP_SH-1:0] RECIP =
    gne_pkg::RECIP_SH'((64'd1 << gne_pkg::RECIP_SH) / GRID_SIZE);

  // Stage 0: captured word
  logic           req0;
  logic [15:0]    xh0, yh0;
  gne_pkg::addr_t idx0;
  gne_pkg::code_t dir0;

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      req0 <= req_type;
      xh0  <= x_coord[31:16];
      yh0  <= y_coord[31:16];
      fx0  <= x_coord[15:0];
      fy0  <= y_coord[15:0];
      idx0 <= entry_index;
      dir0 <= entry_direction;
    end
  end

  // Stage 1: quotient estimate by reciprocal multiply (low by at most one)
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [15:0]       qx1, qy1, xh1, yh1;
  gne_pkg::frac_t    fx1, fy1;
  logic              req1;
  gne_pkg::addr_t    idx1;
  gne_pkg::code_t    dir1;

  assign prod_x = PROD_W'(xh0) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(yh0) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.ld[1]) begin
      qx1  <= prod_x[PROD_W-1:gne_pkg::RECIP_SH];
      qy1  <= prod_y[PROD_W-1:gne_pkg::RECIP_SH];
      xh1  <= xh0;
      yh1  <= yh0;
      fx1  <= fx0;
      fy1  <= fy0;
      req1 <= req0;
      idx1 <= idx0;
      dir1 <= dir0;
    end
  end

  // Stage 2: remainder with one correction step
  logic [23:0]      qg_x, qg_y;
  logic [15:0]      rx_est, ry_est, rx_fix, ry_fix;
  logic [COL_W-1:0] rx2, ry2;
  gne_pkg::frac_t   fx2, fy2;
  logic             req2;
  gne_pkg::addr_t   idx2;
  gne_pkg::code_t   dir2;

  always_comb begin
    qg_x   = 24'(qx1) * 24'(GRID_SIZE);
    qg_y   = 24'(qy1) * 24'(GRID_SIZE);
    rx_est = xh1 - qg_x[15:0];
    ry_est = yh1 - qg_y[15:0];
    rx_fix = (rx_est >= 16'(GRID_SIZE)) ? rx_est - 16'(GRID_SIZE) : rx_est;
    ry_fix = (ry_est >= 16'(GRID_SIZE)) ? ry_est - 16'(GRID_SIZE) : ry_est;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[2]) begin
      rx2  <= rx_fix[COL_W-1:0];
      ry2  <= ry_fix[COL_W-1:0];
      fx2  <= fx1;
      fy2  <= fy1;
      req2 <= req1;
      idx2 <= idx1;
      dir2 <= dir1;
    end
  end

  // Stage 3: wrapped neighbors and table addresses (row * grid + column)
  logic [COL_W-1:0] rx_nb, ry_nb;
  logic [15:0]      row0, row1, a_tl, a_tr, a_bl, a_br;

  always_comb begin
    rx_nb = (rx2 == COL_W'(GRID_SIZE - 1)) ? '0 : rx2 + COL_W'(1);
    ry_nb = (ry2 == COL_W'(GRID_SIZE - 1)) ? '0 : ry2 + COL_W'(1);
    row0  = 16'(ry2) * 16'(GRID_SIZE);
    row1  = 16'(ry_nb) * 16'(GRID_SIZE);
    a_tl  = row0 + 16'(rx2);
    a_tr  = row0 + 16'(rx_nb);
    a_bl  = row1 + 16'(rx2);
    a_br  = row1 + 16'(rx_nb);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[3]) begin
      addr_tl <= a_tl[gne_pkg::ADDR_W-1:0];
      addr_tr <= a_tr[gne_pkg::ADDR_W-1:0];
      addr_bl <= a_bl[gne_pkg::ADDR_W-1:0];
      addr_br <= a_br[gne_pkg::ADDR_W-1:0];
      fx3     <= fx2;
      fy3     <= fy2;
      req3    <= req2;
      idx3    <= idx2;
      dir3    <= dir2;
    end
  end

  // The reciprocal estimate plus one correction must land inside the grid
  a_wrap_x: assert property (@(posedge clk) disable iff (rst)
    ctrl.vld[2] |-> (32'(rx2) < 32'(GRID_SIZE)))
    else $error("x cell not wrapped into the grid");

  a_wrap_y: assert property (@(posedge clk) disable iff (rst)
    ctrl.vld[2] |-> (32'(ry2) < 32'(GRID_SIZE)))
    else $error("y cell not wrapped into the grid");

endmodule

>>> src/gne_fade.sv
// ----------------------------------------------------------------------------
// gne_fade
// Quintic fade 6t^5 - 15t^4 + 10t^3, Q0.16 in, Q1.16 out, at most one operand multiply per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gne_fade (
  input  logic                clk,
  input  logic                rst,
  input  gne_pkg::pipe_ctrl_t ctrl,
  input  gne_pkg::frac_t      t0,
  output gne_pkg::weight_t    s5
);

  localparam int INNER_W = 21;

  // Stage 1: t squared
  logic [31:0]    p1;
  gne_pkg::frac_t t1;

  always_ff @(posedge clk) begin
    if (ctrl.ld[1]) begin
      p1 <= 32'(t0) * 32'(t0);
      t1 <= t0;
    end
  end

  // Stage 2: round t^2, then t^3 product
  logic [32:0] p1_rnd;
  logic [16:0] t2_c, t2;
  logic [33:0] p2;
  gne_pkg::frac_t t2f;

  assign p1_rnd = 33'(p1) + 33'(gne_pkg::HALF_Q16);
  assign t2_c   = p1_rnd[32:16];

  always_ff @(posedge clk) begin
    if (ctrl.ld[2]) begin
      t2  <= t2_c;
      p2  <= 34'(t2_c) * 34'(t1);
      t2f <= t1;
    end
  end

  // Stage 3: round t^3, form 6t^2 - 15t + 10
  logic [33:0]        p2_rnd;
  logic [16:0]        t3;
  logic [INNER_W-1:0] inner_c, inner3;

  assign p2_rnd  = p2 + 34'(gne_pkg::HALF_Q16);
  assign inner_c = INNER_W'(6) * INNER_W'(t2) + INNER_W'(10 * gne_pkg::ONE_Q16)
                 - INNER_W'(15) * INNER_W'(t2f);

  always_ff @(posedge clk) begin
    if (ctrl.ld[3]) begin
      t3     <= p2_rnd[32:16];
      inner3 <= inner_c;
    end
  end

  // Stage 4: full polynomial product
  logic [37:0] p4;

  always_ff @(posedge clk) begin
    if (ctrl.ld[4]) begin
      p4 <= 38'(t3) * 38'(inner3);
    end
  end

  // Stage 5: round and clamp to one
  logic [37:0] p4_rnd;
  logic [21:0] s_raw;

  assign p4_rnd = p4 + 38'(gne_pkg::HALF_Q16);
  assign s_raw  = p4_rnd[37:16];

  always_ff @(posedge clk) begin
    if (ctrl.ld[5]) begin
      s5 <= (s_raw > 22'(gne_pkg::ONE_Q16)) ? 17'(gne_pkg::ONE_Q16) : s_raw[16:0];
    end
  end

  // Operand bounds that keep the last multiply within 17 x 21 bits
  a_t3_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.vld[4] |-> (t3 <= 17'(gne_pkg::ONE_Q16))
                 && (inner3 <= INNER_W'(10 * gne_pkg::ONE_Q16)))
    else $error("fade operand out of range");

endmodule

>>> src/gne_blend.sv
// ----------------------------------------------------------------------------
// gne_blend
// Corner dot products, bilinear interpolation and Q1.15 output saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gne_blend (
  input  logic                clk,
  input  gne_pkg::pipe_ctrl_t ctrl,
  input  gne_pkg::frac_t      fx3,
  input  gne_pkg::frac_t      fy3,
  input  gne_pkg::code_t      code_tl,
  input  gne_pkg::code_t      code_tr,
  input  gne_pkg::code_t      code_bl,
  input  gne_pkg::code_t      code_br,
  input  gne_pkg::weight_t    sx5,
  input  gne_pkg::weight_t    sy5,
  output logic signed [15:0]  noise_value
);

  localparam int P6_W = 37;
  localparam int P8_W = 39;

  // Stage 4: hold fractions alongside the table read data
  gne_pkg::frac_t fx4, fy4;

  always_ff @(posedge clk) begin
    if (ctrl.ld[gne_pkg::ST_RAM]) begin
      fx4 <= fx3;
      fy4 <= fy3;
    end
  end

  // Stage 5: dot products with the four corner offsets
  gne_pkg::dot_t dx0, dy0, dx1, dy1;
  gne_pkg::dot_t tl5, tr5, bl5, br5;

  always_comb begin
    dx0 = gne_pkg::DOT_W'(fx4);
    dy0 = gne_pkg::DOT_W'(fy4);
    dx1 = dx0 - gne_pkg::DOT_W'(gne_pkg::ONE_Q16);
    dy1 = dy0 - gne_pkg::DOT_W'(gne_pkg::ONE_Q16);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[5]) begin
      tl5 <= gne_pkg::grad_dot(code_tl, dx0, dy0);
      tr5 <= gne_pkg::grad_dot(code_tr, dx1, dy0);
      bl5 <= gne_pkg::grad_dot(code_bl, dx0, dy1);
      br5 <= gne_pkg::grad_dot(code_br, dx1, dy1);
    end
  end

  // Stage 6: vertical weight times edge differences
  logic signed [18:0]    dl, dr;
  logic signed [17:0]    wy;
  logic signed [P6_W-1:0] pl6, pr6;
  gne_pkg::dot_t         tl6, tr6;
  gne_pkg::weight_t      sx6;

  always_comb begin
    dl = 19'(bl5) - 19'(tl5);
    dr = 19'(br5) - 19'(tr5);
    wy = $signed({1'b0, sy5});
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[6]) begin
      pl6 <= P6_W'(wy) * P6_W'(dl);
      pr6 <= P6_W'(wy) * P6_W'(dr);
      tl6 <= tl5;
      tr6 <= tr5;
      sx6 <= sx5;
    end
  end

  // Stage 7: finish the left and right edge blends
  logic signed [P6_W-1:0] pl_sh, pr_sh;
  gne_pkg::lerp_t         left7, right7;
  gne_pkg::weight_t       sx7;

  always_comb begin
    pl_sh = (pl6 + P6_W'(gne_pkg::HALF_Q16)) >>> 16;
    pr_sh = (pr6 + P6_W'(gne_pkg::HALF_Q16)) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[7]) begin
      left7  <= gne_pkg::LERP_W'(tl6) + gne_pkg::LERP_W'(pl_sh);
      right7 <= gne_pkg::LERP_W'(tr6) + gne_pkg::LERP_W'(pr_sh);
      sx7    <= sx6;
    end
  end

  // Stage 8: horizontal weight times the edge difference
  logic signed [20:0]     dh;
  logic signed [17:0]     wx;
  logic signed [P8_W-1:0] p8;
  gne_pkg::lerp_t         left8;

  always_comb begin
    dh = 21'(right7) - 21'(left7);
    wx = $signed({1'b0, sx7});
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[8]) begin
      p8    <= P8_W'(wx) * P8_W'(dh);
      left8 <= left7;
    end
  end

  // Stage 9: final blend, halve to Q1.15 and saturate
  logic signed [P8_W-1:0] p8_sh;
  logic signed [20:0]     v9, h9;
  logic signed [15:0]     sat9;

  always_comb begin
    p8_sh = (p8 + P8_W'(gne_pkg::HALF_Q16)) >>> 16;
    v9    = 21'(left8) + 21'(p8_sh);
    h9    = (v9 + 21'sd1) >>> 1;
    if (h9 > 21'sd32767) begin
      sat9 = 16'sh7fff;
    end else if (h9 < -21'sd32768) begin
      sat9 = -16'sh8000;
    end else begin
      sat9 = h9[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[9]) begin
      noise_value <= sat9;
    end
  end

endmodule
